FILE: src/baro_pressure_temperature_compensation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define BPTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bptc assertion failed");

// Non-overlapping implication, checked in the cycle after the antecedent.
`define BPTC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bptc assertion failed");

`endif

FILE: src/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Widths, constants, register indexes and stage types of the compensation block.
// ----------------------------------------------------------------------------
package bptc_pkg;

    localparam int W_RAW   = 24;
    localparam int W_CAL   = 16;
    localparam int W_IDX   = 3;
    localparam int W_DT    = 25;
    localparam int W_TEMP  = 19;
    localparam int W_OFF   = 36;
    localparam int W_SENS  = 35;
    localparam int W_T2    = 17;
    localparam int W_SQ    = 36;
    localparam int W_CORR  = 39;
    localparam int W_OFFN  = 41;
    localparam int W_SENSN = 40;
    localparam int W_PRESS = 32;

    // Accept edge to the edge at which the result word is taken.
    localparam int LATENCY = 11;

    localparam logic signed [W_TEMP-1:0] TEMP_REF = 19'sd2000;
    localparam logic signed [W_TEMP-1:0] TEMP_LOW = -19'sd1500;

    typedef enum logic [W_IDX-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [W_CAL-1:0] sens;
        logic [W_CAL-1:0] off;
        logic [W_CAL-1:0] tcs;
        logic [W_CAL-1:0] tco;
        logic [W_CAL-1:0] tref;
        logic [W_CAL-1:0] tempsens;
    } cal_t;

    typedef struct packed {
        logic                     valid;
        logic [W_RAW-1:0]         d1;
        logic signed [W_TEMP-1:0] temp;
        logic signed [W_OFF-1:0]  off;
        logic signed [W_SENS-1:0] sens;
        logic [W_T2-1:0]          t2;
    } front_t;

    typedef struct packed {
        logic                      valid;
        logic [W_RAW-1:0]          d1;
        logic signed [W_OFFN-1:0]  off_n;
        logic signed [W_SENSN-1:0] sens_n;
        logic signed [W_TEMP-1:0]  tout;
    } corr_t;

endpackage

FILE: src/bptc_cfg.sv
// ----------------------------------------------------------------------------
// bptc_cfg
// Calibration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bptc_cfg
    import bptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [W_IDX-1:0] cfg_index,
    input  logic [W_CAL-1:0] cfg_data,
    output cal_t             cal
);

    cal_t cal_reg;
    cal_t cal_next;

    assign cfg_ready = 1'b1;
    assign cal       = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SENS:     cal_next.sens     = cfg_data;
                CFG_OFF:      cal_next.off      = cfg_data;
                CFG_TCS:      cal_next.tcs      = cfg_data;
                CFG_TCO:      cal_next.tco      = cfg_data;
                CFG_TREF:     cal_next.tref     = cfg_data;
                CFG_TEMPSENS: cal_next.tempsens = cfg_data;
                default:      cal_next          = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

endmodule

FILE: src/bptc_front.sv
// ----------------------------------------------------------------------------
// bptc_front
// First-order stages: dT, the three calibration products and dT squared,
// then temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bptc_front
    import bptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [W_RAW-1:0] d1,
    input  logic [W_RAW-1:0] d2,
    input  cal_t             cal,
    output front_t           fr
);

    // Stage 1: dT.
    logic                   s1_valid_reg;
    logic [W_RAW-1:0]       s1_d1_reg;
    logic signed [W_DT-1:0] dt_next;
    logic signed [W_DT-1:0] dt_reg;

    // Stage 2: products.
    logic                   s2_valid_reg;
    logic [W_RAW-1:0]       s2_d1_reg;
    logic signed [41:0]     mt_next;
    logic signed [41:0]     mo_next;
    logic signed [41:0]     ms_next;
    logic signed [49:0]     dtsq_next;
    logic signed [18:0]     mt_reg;
    logic signed [34:0]     mo_reg;
    logic signed [33:0]     ms_reg;
    logic [W_T2-1:0]        t2_reg;

    // Stage 3: temperature, offset, sensitivity.
    logic                     s3_valid_reg;
    logic [W_RAW-1:0]         s3_d1_reg;
    logic signed [W_TEMP-1:0] temp_next;
    logic signed [W_TEMP-1:0] temp_reg;
    logic signed [W_OFF-1:0]  off_next;
    logic signed [W_OFF-1:0]  off_reg;
    logic signed [W_SENS-1:0] sens_next;
    logic signed [W_SENS-1:0] sens_reg;
    logic [W_T2-1:0]          s3_t2_reg;

    assign dt_next = $signed({1'b0, d2}) - $signed({1'b0, cal.tref, 8'b0});

    assign mt_next   = dt_reg * $signed({1'b0, cal.tempsens});
    assign mo_next   = dt_reg * $signed({1'b0, cal.tco});
    assign ms_next   = dt_reg * $signed({1'b0, cal.tcs});
    assign dtsq_next = dt_reg * dt_reg;

    // Upper bits of each product are the floor shifts; the values fit the slices.
    assign temp_next = TEMP_REF + mt_reg;
    assign off_next  = $signed({4'b0, cal.off, 16'b0}) + $signed({mo_reg[34], mo_reg});
    assign sens_next = $signed({4'b0, cal.sens, 15'b0}) + $signed({ms_reg[33], ms_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d1_reg <= d1;
        dt_reg    <= dt_next;

        s2_d1_reg <= s1_d1_reg;
        mt_reg    <= mt_next[41:23];
        mo_reg    <= mo_next[41:7];
        ms_reg    <= ms_next[41:8];
        t2_reg    <= dtsq_next[47:31];

        s3_d1_reg <= s2_d1_reg;
        temp_reg  <= temp_next;
        off_reg   <= off_next;
        sens_reg  <= sens_next;
        s3_t2_reg <= t2_reg;
    end

    assign fr.valid = s3_valid_reg;
    assign fr.d1    = s3_d1_reg;
    assign fr.temp  = temp_reg;
    assign fr.off   = off_reg;
    assign fr.sens  = sens_reg;
    assign fr.t2    = s3_t2_reg;

endmodule

FILE: src/bptc_corr.sv
// ----------------------------------------------------------------------------
// bptc_corr
// Second-order low-temperature correction of offset, sensitivity and
// temperature.
// ----------------------------------------------------------------------------
module bptc_corr
    import bptc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  front_t fr,
    output corr_t  cr
);

    logic [4:0] valid_reg;

    // Stage 1: threshold distances and flags, and the output temperature.
    logic [W_RAW-1:0]         c1_d1_reg;
    logic signed [W_OFF-1:0]  c1_off_reg;
    logic signed [W_SENS-1:0] c1_sens_reg;
    logic signed [W_TEMP:0]   ta_next;
    logic signed [W_TEMP:0]   tb_next;
    logic signed [W_TEMP:0]   ta_reg;
    logic signed [W_TEMP:0]   tb_reg;
    logic                     lt_ref_reg;
    logic                     lt_low_reg;
    logic signed [W_TEMP-1:0] t2_use;
    logic signed [W_TEMP-1:0] tout_next;
    logic signed [W_TEMP-1:0] c1_tout_reg;

    // Stage 2: squares.
    logic [W_RAW-1:0]         c2_d1_reg;
    logic signed [W_OFF-1:0]  c2_off_reg;
    logic signed [W_SENS-1:0] c2_sens_reg;
    logic signed [W_TEMP-1:0] c2_tout_reg;
    logic signed [39:0]       sqa_next;
    logic signed [39:0]       sqb_next;
    logic [W_SQ-1:0]          a_reg;
    logic [W_SQ-1:0]          b_reg;

    // Stage 3: small constant multiples.
    logic [W_RAW-1:0]         c3_d1_reg;
    logic signed [W_OFF-1:0]  c3_off_reg;
    logic signed [W_SENS-1:0] c3_sens_reg;
    logic signed [W_TEMP-1:0] c3_tout_reg;
    logic [W_CORR-1:0]        a5_reg;
    logic [W_CORR-1:0]        b7_reg;
    logic [W_CORR-1:0]        b11_reg;

    // Stage 4: correction terms.
    logic [W_RAW-1:0]         c4_d1_reg;
    logic signed [W_OFF-1:0]  c4_off_reg;
    logic signed [W_SENS-1:0] c4_sens_reg;
    logic signed [W_TEMP-1:0] c4_tout_reg;
    logic [W_CORR-1:0]        off2_reg;
    logic [W_CORR-1:0]        sens2_reg;

    // Stage 5: corrected offset and sensitivity.
    logic [W_RAW-1:0]          c5_d1_reg;
    logic signed [W_TEMP-1:0]  c5_tout_reg;
    logic signed [W_OFFN-1:0]  offn_reg;
    logic signed [W_SENSN-1:0] sensn_reg;

    assign ta_next   = $signed({fr.temp[W_TEMP-1], fr.temp})
                     - $signed({TEMP_REF[W_TEMP-1], TEMP_REF});
    assign tb_next   = $signed({fr.temp[W_TEMP-1], fr.temp})
                     - $signed({TEMP_LOW[W_TEMP-1], TEMP_LOW});
    // The dT squared term only applies below the upper knee.
    assign t2_use    = (fr.temp < TEMP_REF) ? $signed({2'b00, fr.t2})
                                            : $signed({W_TEMP{1'b0}});
    // The true difference always fits the temperature width.
    assign tout_next = fr.temp - t2_use;

    assign sqa_next = ta_reg * ta_reg;
    assign sqb_next = tb_reg * tb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], fr.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        c1_d1_reg   <= fr.d1;
        c1_off_reg  <= fr.off;
        c1_sens_reg <= fr.sens;
        c1_tout_reg <= tout_next;
        ta_reg      <= ta_next;
        tb_reg      <= tb_next;
        lt_ref_reg  <= fr.temp < TEMP_REF;
        lt_low_reg  <= fr.temp < TEMP_LOW;

        c2_d1_reg   <= c1_d1_reg;
        c2_off_reg  <= c1_off_reg;
        c2_sens_reg <= c1_sens_reg;
        c2_tout_reg <= c1_tout_reg;
        a_reg       <= lt_ref_reg ? sqa_next[W_SQ-1:0] : '0;
        b_reg       <= lt_low_reg ? sqb_next[W_SQ-1:0] : '0;

        c3_d1_reg   <= c2_d1_reg;
        c3_off_reg  <= c2_off_reg;
        c3_sens_reg <= c2_sens_reg;
        c3_tout_reg <= c2_tout_reg;
        a5_reg      <= {1'b0, a_reg, 2'b00} + {3'b000, a_reg};
        b7_reg      <= {b_reg, 3'b000} - {3'b000, b_reg};
        b11_reg     <= {b_reg, 3'b000} + {2'b00, b_reg, 1'b0} + {3'b000, b_reg};

        c4_d1_reg   <= c3_d1_reg;
        c4_off_reg  <= c3_off_reg;
        c4_sens_reg <= c3_sens_reg;
        c4_tout_reg <= c3_tout_reg;
        off2_reg    <= (a5_reg >> 1) + b7_reg;
        sens2_reg   <= (a5_reg >> 2) + (b11_reg >> 1);

        c5_d1_reg   <= c4_d1_reg;
        c5_tout_reg <= c4_tout_reg;
        offn_reg    <= W_OFFN'(c4_off_reg) - $signed({2'b00, off2_reg});
        sensn_reg   <= W_SENSN'(c4_sens_reg) - $signed({1'b0, sens2_reg});
    end

    assign cr.valid  = valid_reg[4];
    assign cr.d1     = c5_d1_reg;
    assign cr.off_n  = offn_reg;
    assign cr.sens_n = sensn_reg;
    assign cr.tout   = c5_tout_reg;

endmodule

FILE: src/bptc_press.sv
// ----------------------------------------------------------------------------
// bptc_press
// Pressure product in two partial products, final scaling and the result
// registers.
// ----------------------------------------------------------------------------
module bptc_press
    import bptc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  corr_t                    cr,
    output logic                     done,
    output logic signed [W_PRESS-1:0] pressure_centi_mbar,
    output logic signed [W_TEMP-1:0]  temperature_centi_c
);

    // Stage 1: partial products over the low and high halves of the sensitivity.
    logic                     p1_valid_reg;
    logic signed [W_OFFN-1:0] p1_off_reg;
    logic signed [W_TEMP-1:0] p1_tout_reg;
    logic [43:0]              pplo_next;
    logic signed [44:0]       pphi_next;
    logic [43:0]              pplo_reg;
    logic signed [44:0]       pphi_reg;

    // Stage 2: full product.
    logic                     p2_valid_reg;
    logic signed [W_OFFN-1:0] p2_off_reg;
    logic signed [W_TEMP-1:0] p2_tout_reg;
    logic signed [64:0]       prod_next;
    logic signed [64:0]       prod_reg;

    // Stage 3: result registers.
    logic signed [46:0]        diff_next;
    logic                      done_reg;
    logic signed [W_PRESS-1:0] press_reg;
    logic signed [W_TEMP-1:0]  temp_reg;

    assign pplo_next = cr.d1 * cr.sens_n[19:0];
    assign pphi_next = $signed({1'b0, cr.d1}) * $signed(cr.sens_n[W_SENSN-1:20]);

    assign prod_next = $signed({pphi_reg, 20'b0}) + $signed({21'b0, pplo_reg});

    // Floor of the product over 2^21 minus the offset; the floor over 2^15 is the slice.
    assign diff_next = $signed({{3{prod_reg[64]}}, prod_reg[64:21]}) - 47'(p2_off_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cr.valid;
            p2_valid_reg <= p1_valid_reg;
            done_reg     <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_off_reg  <= cr.off_n;
        p1_tout_reg <= cr.tout;
        pplo_reg    <= pplo_next;
        pphi_reg    <= pphi_next;

        p2_off_reg  <= p1_off_reg;
        p2_tout_reg <= p1_tout_reg;
        prod_reg    <= prod_next;

        press_reg   <= diff_next[46:15];
        temp_reg    <= p2_tout_reg;
    end

    assign done                = done_reg;
    assign pressure_centi_mbar = press_reg;
    assign temperature_centi_c = temp_reg;

endmodule

FILE: src/baro_pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temperature_compensation
// Second-order compensated pressure and temperature from raw conversions.
//
//   channel   handshake              words
//   -------   --------------------   -----------------------------------------
//   command   start / busy           raw_pressure, raw_temperature
//   result    done (one-cycle)       pressure_centi_mbar, temperature_centi_c
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is taken every cycle; busy is always low. done and the result word
// come out of the eleven-stage pipeline of the dT, first-order, correction and
// pressure-product stages.
// Reset clears the calibration registers and all stage valid bits.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
`include "baro_pressure_temperature_compensation_assert.svh"

module baro_pressure_temperature_compensation
    import bptc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [W_RAW-1:0]          raw_pressure,
    input  logic [W_RAW-1:0]          raw_temperature,
    output logic                      done,
    output logic signed [W_PRESS-1:0] pressure_centi_mbar,
    output logic signed [W_TEMP-1:0]  temperature_centi_c,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [W_IDX-1:0]          cfg_index,
    input  logic [W_CAL-1:0]          cfg_data
);

    cal_t   cal;
    front_t fr;
    corr_t  cr;
    logic   accept;

    // Every stage advances each cycle, so a new word is always welcome.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    bptc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    bptc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .d1     (raw_pressure),
        .d2     (raw_temperature),
        .cal    (cal),
        .fr     (fr)
    );

    bptc_corr u_corr (
        .clk   (clk),
        .rst_n (rst_n),
        .fr    (fr),
        .cr    (cr)
    );

    bptc_press u_press (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cr                  (cr),
        .done                (done),
        .pressure_centi_mbar (pressure_centi_mbar),
        .temperature_centi_c (temperature_centi_c)
    );

    `BPTC_ASSERT_IMP(a_word_comes_out, accept, ##LATENCY done)
    `BPTC_ASSERT_IMP(a_no_spurious_done, !accept, ##LATENCY !done)
    `BPTC_ASSERT_NXT(a_bad_index_ignored, cfg_valid && (cfg_index > CFG_TEMPSENS), $stable(cal))

endmodule
